// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/etc1_pkg.sv
// ----------------------------------------------------------------------------
// etc1_pkg
// Types, constants and helper functions for the ETC1 block decoder.
// ----------------------------------------------------------------------------
package etc1_pkg;

    localparam int unsigned TexelCount = 16;

    typedef logic [1:0] coord_t;
    typedef logic [3:0] texel_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam logic [7:0] ModSmall [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
                                            8'd18, 8'd24, 8'd33, 8'd47};
    localparam logic [7:0] ModLarge [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
                                            8'd60, 8'd80, 8'd106, 8'd183};

    function automatic logic [7:0] expand4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [9:0] v);
        logic [7:0] res;
        if (v < 10'sd0)
            res = 8'd0;
        else if (v > 10'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

// File: rtl/etc1_block_decoder.sv
// ----------------------------------------------------------------------------
// etc1_block_decoder
// ETC1 block decoder: one 64-bit block in, sixteen RGB888 texels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive block_word and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low.
//   Output: texels leave in raster order, one per cycle, each shown for one
//   cycle with texel_valid high; last_texel marks the sixteenth.
//   Timing: the accepting edge loads the counter and active flag; the output
//   registers then take texel 0, and the other texels follow in raster order.
//   Overlap: a single texel datapath decodes the blocks one after another.
//   busy drops while texel 15 is being formed, so the next block enters
//   then and the texel stream runs without gaps.
//   Reset: clears the texel counter and strobe; no texel is emitted until a
//   block is accepted.
//   The receiver cannot stall: it must take each texel in its cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etc1_block_decoder
    import etc1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] block_word,
    output logic        texel_valid,
    output logic [1:0]  texel_x,
    output logic [1:0]  texel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_texel
);

    localparam texel_idx_t LastIdx = texel_idx_t'(TexelCount - 1);

    logic [63:0] block_reg;
    texel_idx_t  cnt_reg;
    logic        active_reg;
    logic        valid_reg;
    logic        last_reg;
    coord_t      x_reg;
    coord_t      y_reg;
    rgb_t        color_reg;
    rgb_t        color_next;
    logic        accept;

    assign busy   = active_reg && (cnt_reg != LastIdx);
    assign accept = start && !busy;

    etc1_texel_calc u_texel
    (
        .block_word (block_reg),
        .texel_x    (cnt_reg[1:0]),
        .texel_y    (cnt_reg[3:2]),
        .color      (color_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= active_reg;
            last_reg  <= active_reg && (cnt_reg == LastIdx);
            if (accept)
            begin
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + texel_idx_t'(1);
                if (cnt_reg == LastIdx)
                    active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            block_reg <= block_word;
        x_reg     <= cnt_reg[1:0];
        y_reg     <= cnt_reg[3:2];
        color_reg <= color_next;
    end

    assign texel_valid = valid_reg;
    assign texel_x     = x_reg;
    assign texel_y     = y_reg;
    assign red         = color_reg.red;
    assign green       = color_reg.green;
    assign blue        = color_reg.blue;
    assign last_texel  = last_reg;

    `ASSERT_IMPLY(a_last_pos, clk, rst_n, last_texel, texel_valid && texel_x == 2'd3 && texel_y == 2'd3)
    `ASSERT_NEXT(a_first_texel, clk, rst_n, active_reg && cnt_reg == '0, texel_valid && {x_reg, y_reg} == '0)
    `ASSERT_NEXT(a_no_gap, clk, rst_n, texel_valid && !last_texel, texel_valid)
    `ASSERT_NEXT(a_busy_emits, clk, rst_n, busy, texel_valid && !last_texel)

endmodule

// File: rtl/etc1_texel_calc.sv
// ----------------------------------------------------------------------------
// etc1_texel_calc
// Decodes the color of one texel of an ETC1 block from its tile position.
// ----------------------------------------------------------------------------
module etc1_texel_calc
    import etc1_pkg::*;
(
    input  logic [63:0] block_word,
    input  coord_t      texel_x,
    input  coord_t      texel_y,
    output rgb_t        color
);

    function automatic logic [7:0] base_of(input logic [7:0] chan_bits,
                                           input logic diff, input logic sub);
        logic [4:0] sum5;
        logic [7:0] res;
        sum5 = chan_bits[7:3] + {{2{chan_bits[2]}}, chan_bits[2:0]};
        if (!diff)
            res = sub ? expand4(chan_bits[3:0]) : expand4(chan_bits[7:4]);
        else
            res = sub ? expand5(sum5) : expand5(chan_bits[7:3]);
        return res;
    endfunction

    function automatic logic [7:0] apply_mod(input logic [7:0] base,
                                             input logic [7:0] mag,
                                             input logic negative);
        logic signed [9:0] b;
        logic signed [9:0] m;
        b = $signed({2'b00, base});
        m = $signed({2'b00, mag});
        return clamp8(negative ? (b - m) : (b + m));
    endfunction

    logic        diff;
    logic        flip;
    logic        sub;
    logic [3:0]  pos;
    logic [15:0] lsb_bits;
    logic [15:0] msb_bits;
    logic [2:0]  codeword;
    logic [7:0]  mag;
    logic        negative;

    always_comb
    begin
        diff     = block_word[33];
        flip     = block_word[32];
        sub      = flip ? texel_y[1] : texel_x[1];
        pos      = {texel_x, texel_y};
        lsb_bits = block_word[15:0];
        msb_bits = block_word[31:16];
        codeword = sub ? block_word[36:34] : block_word[39:37];
        mag      = lsb_bits[pos] ? ModLarge[codeword] : ModSmall[codeword];
        negative = msb_bits[pos];

        color.red   = apply_mod(base_of(block_word[63:56], diff, sub), mag, negative);
        color.green = apply_mod(base_of(block_word[55:48], diff, sub), mag, negative);
        color.blue  = apply_mod(base_of(block_word[47:40], diff, sub), mag, negative);
    end

endmodule
